// ----- rtl/flpte_pkg.sv -----
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared widths, field layout and codes of the four-level page table engine.
// ----------------------------------------------------------------------------
package flpte_pkg;

    // entry and address layout
    localparam int ENTRY_W           = 52;
    localparam int FLAG_W            = 12;
    localparam int FRAME_W           = ENTRY_W - FLAG_W;
    localparam int VA_W              = 48;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);

    // present bit of an entry
    localparam logic [FLAG_W-1:0] PRESENT_FLAG = 12'h001;

    // command codes
    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_MEM      = 2'd1,
        STATUS_NOT_PRESENT = 2'd2
    } status_t;

endpackage

// ----- rtl/flpte_table_store.sv -----
// ----------------------------------------------------------------------------
// flpte_table_store
// Single-port table store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module flpte_table_store
    import flpte_pkg::*;
#(
    parameter int ADDR_W = 15,
    parameter int DEPTH  = 32768
)
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [ENTRY_W-1:0] wdata,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/four_level_page_table_engine.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_engine
// Map, unmap and translate of 4 KiB pages over a four-level radix table tree.
// ----------------------------------------------------------------------------
// All tables sit in one single-port synchronous store of TABLE_POOL_PAGES
// tables of 512 entries; table 0 is the root and map takes new tables from the
// pool in order. After reset the block sweeps the store to zero, one entry a
// cycle, and holds s_tready low meanwhile (configuration writes are taken
// throughout). A command is then accepted, each table level issues its read,
// then evaluates the entry and writes back where needed, and the result is
// handed to the output register; a walk can stop early, and the unused command
// code goes straight to the result. The four dependent reads share the one
// memory port. The next command is accepted while a result still waits on the
// master side.
module four_level_page_table_engine
    import flpte_pkg::*;
#(
    parameter int TABLE_POOL_PAGES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: table_entry_flags
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata,
    // command stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
    input  logic [1:0]   s_tuser,   // command[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // phys_result[51:0], zero pad[55:52]
    output logic [2:0]   m_tuser    // status[1:0], mapped[2]
);

    localparam int TBL_W  = $clog2(TABLE_POOL_PAGES);
    localparam int CNT_W  = $clog2(TABLE_POOL_PAGES + 1);
    localparam int ADDR_W = TBL_W + IDX_W;
    localparam int DEPTH  = TABLE_POOL_PAGES * ENTRIES_PER_TABLE;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clear_addr_reg, clear_addr_next;
    logic [CNT_W-1:0]    next_free_reg, next_free_next;
    logic [FLAG_W-1:0]   flags_reg;
    logic [1:0]          level_reg, level_next;
    logic [TBL_W-1:0]    table_reg, table_next;
    cmd_t                cmd_reg, cmd_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [ENTRY_W-1:0]  pa_reg, pa_next;
    logic [FLAG_W-1:0]   pflags_reg, pflags_next;
    status_t             res_status_reg, res_status_next;
    logic [ENTRY_W-1:0]  res_phys_reg, res_phys_next;
    logic                m_valid_reg, m_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]  out_phys_reg, out_phys_next;
    logic                out_mapped_reg, out_mapped_next;

    logic                mem_en, mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;
    logic [IDX_W-1:0]    level_idx;
    logic [FRAME_W-1:0]  entry_frame;
    logic                entry_ok;
    logic                pool_empty;
    logic                in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0, out_phys_reg};
    assign m_tuser   = {out_mapped_reg, out_status_reg};

    // index of the current level in the virtual address
    always_comb
    begin
        case (level_reg)
            2'd0:    level_idx = va_reg[47:39];
            2'd1:    level_idx = va_reg[38:30];
            2'd2:    level_idx = va_reg[29:21];
            default: level_idx = va_reg[20:12];
        endcase
    end

    // intermediate entry check: present and naming a table of the pool
    assign entry_frame = mem_rdata[ENTRY_W-1:FLAG_W];
    assign entry_ok    = mem_rdata[0] && (entry_frame < FRAME_W'(TABLE_POOL_PAGES));
    assign pool_empty  = (next_free_reg >= CNT_W'(TABLE_POOL_PAGES));

    // table store
    flpte_table_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 12'h003;
        end
        else if (cfg_we)
        begin
            flags_reg <= cfg_wdata;
        end
    end

    // walk sequencer
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        next_free_next  = next_free_reg;
        level_next      = level_reg;
        table_next      = table_reg;
        cmd_next        = cmd_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        pflags_next     = pflags_reg;
        res_status_next = res_status_reg;
        res_phys_next   = res_phys_reg;
        m_valid_next    = m_valid_reg;
        out_status_next = out_status_reg;
        out_phys_next   = out_phys_reg;
        out_mapped_next = out_mapped_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = {table_reg, level_idx};
        mem_wdata       = '0;

        // output register drains independently
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clear_addr_reg;
                if (clear_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = cmd_t'(s_tuser[1:0]);
                    va_next         = s_tdata[47:0];
                    pa_next         = s_tdata[99:48];
                    pflags_next     = s_tdata[111:100];
                    level_next      = 2'd0;
                    table_next      = '0;
                    res_status_next = STATUS_OK;
                    res_phys_next   = '0;
                    if (cmd_t'(s_tuser[1:0]) == CMD_NONE)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                mem_en     = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (level_reg != 2'd3)
                begin
                    // upper levels: follow, allocate or stop
                    if (entry_ok)
                    begin
                        table_next = entry_frame[TBL_W-1:0];
                        level_next = level_reg + 2'd1;
                        state_next = ST_READ;
                    end
                    else if (cmd_reg == CMD_MAP)
                    begin
                        if (pool_empty)
                        begin
                            res_status_next = STATUS_NO_MEM;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            mem_en         = 1'b1;
                            mem_we         = 1'b1;
                            mem_wdata      = {FRAME_W'(next_free_reg[TBL_W-1:0]),
                                              flags_reg | PRESENT_FLAG};
                            table_next     = next_free_reg[TBL_W-1:0];
                            next_free_next = next_free_reg + CNT_W'(1);
                            level_next     = level_reg + 2'd1;
                            state_next     = ST_READ;
                        end
                    end
                    else
                    begin
                        res_status_next = STATUS_NOT_PRESENT;
                        state_next      = ST_DONE;
                    end
                end
                else
                begin
                    // leaf level
                    state_next = ST_DONE;
                    case (cmd_reg)
                        CMD_MAP:
                        begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_wdata = {pa_reg[ENTRY_W-1:FLAG_W], pflags_reg | PRESENT_FLAG};
                        end
                        CMD_UNMAP:
                        begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_wdata = '0;
                        end
                        CMD_TRANSLATE:
                        begin
                            if (mem_rdata[0])
                            begin
                                res_phys_next = {entry_frame, va_reg[FLAG_W-1:0]};
                            end
                            else
                            begin
                                res_status_next = STATUS_NOT_PRESENT;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // hand over once the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_phys_next   = res_phys_reg;
                    out_mapped_next = (cmd_reg == CMD_TRANSLATE) && (res_phys_reg != '0);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            next_free_reg  <= CNT_W'(1);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            next_free_reg  <= next_free_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        level_reg      <= level_next;
        table_reg      <= table_next;
        cmd_reg        <= cmd_next;
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        pflags_reg     <= pflags_next;
        res_status_reg <= res_status_next;
        res_phys_reg   <= res_phys_next;
        out_status_reg <= out_status_next;
        out_phys_reg   <= out_phys_next;
        out_mapped_reg <= out_mapped_next;
    end

    // pool counter never runs past the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= CNT_W'(TABLE_POOL_PAGES))
        else $error("table pool counter past pool size");

    // an accepted transaction closes the slave side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("slave side still open after accept");

    // a result only appears from the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    // every walk starts at the root table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && level_reg == 2'd0) |-> (table_reg == '0))
        else $error("walk does not start at root");

    // tables are only taken while evaluating an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_free_reg) |-> $past(state_reg == ST_EVAL && cmd_reg == CMD_MAP))
        else $error("table allocated outside a map walk");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the four-level page table engine.
// ----------------------------------------------------------------------------
// Commands go in through a queue-fed driver with random gaps. Results are
// taken by a monitor with random back-pressure, and each one is checked
// against a walk of a local copy of the table store. A directed set of corner
// commands comes first. Random phases follow, each under a different
// table_entry_flags setting. Addresses are drawn mostly from a small set of
// per-level indexes and from pages already mapped, so walks go deep and the
// table pool is run dry part way through.
module testbench;

    import flpte_pkg::*;

    localparam int POOL_TABLES   = 64;
    localparam int STORE_ENTRIES = POOL_TABLES * ENTRIES_PER_TABLE;
    localparam int QUIET_LIMIT   = 100000;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 18;

    typedef struct packed {
        cmd_t              cmd;
        logic [VA_W-1:0]   va;
        logic [ENTRY_W-1:0] pa;
        logic [FLAG_W-1:0] pflags;
    } page_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] phys;
        logic               mapped;
    } walk_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [11:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;   // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
    logic [1:0]   s_tuser = '0;   // command[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;        // phys_result[51:0], zero pad[55:52]
    logic [2:0]   m_tuser;        // status[1:0], mapped[2]

    // local copy of the table tree
    logic [ENTRY_W-1:0] page_store [0:STORE_ENTRIES-1];
    int unsigned        free_table;
    logic [FLAG_W-1:0]  entry_flags_model;

    page_cmd_t     pending_cmds[$];
    walk_result_t  expected_results[$];
    logic [VA_W-1:0] known_pages[$];
    logic [8:0]    level_palette [0:3][0:3];

    int items_total   = 0;
    int sent_count    = 0;
    int results_count = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    four_level_page_table_engine #(
        .TABLE_POOL_PAGES(POOL_TABLES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // table index used at one level of the walk
    function automatic int unsigned level_slot(logic [VA_W-1:0] va, int unsigned lvl);
        logic [VA_W-1:0] shifted;
        shifted = va >> (12 + 9 * (3 - lvl));
        return int'(shifted[IDX_W-1:0]);
    endfunction

    // follow an intermediate entry; tables outside the pool count as absent
    function automatic bit entry_points_to(logic [ENTRY_W-1:0] e, output int unsigned tbl);
        tbl = 0;
        if (!e[0] || e[ENTRY_W-1:FLAG_W] >= POOL_TABLES)
            return 1'b0;
        tbl = int'(e[ENTRY_W-1:FLAG_W]);
        return 1'b1;
    endfunction

    // apply one command to the local tree and work out its result
    function automatic walk_result_t walk_tables(cmd_t cmd, logic [VA_W-1:0] va,
                                                 logic [ENTRY_W-1:0] pa,
                                                 logic [FLAG_W-1:0] pflags);
        walk_result_t r;
        int unsigned  tbl, nxt, slot, lvl, e;
        bit           path_ok;
        r.status = STATUS_OK;
        r.phys   = '0;
        r.mapped = 1'b0;
        tbl      = 0;
        path_ok  = 1'b1;
        case (cmd)
            CMD_MAP:
            begin
                for (lvl = 0; lvl < 3 && path_ok; lvl++)
                begin
                    slot = tbl * ENTRIES_PER_TABLE + level_slot(va, lvl);
                    if (entry_points_to(page_store[slot], nxt))
                        tbl = nxt;
                    else if (free_table >= POOL_TABLES)
                        path_ok = 1'b0;
                    else
                    begin
                        // take the next table from the pool
                        nxt = free_table;
                        free_table++;
                        for (e = 0; e < ENTRIES_PER_TABLE; e++)
                            page_store[nxt * ENTRIES_PER_TABLE + e] = '0;
                        page_store[slot] = {FRAME_W'(nxt), entry_flags_model | PRESENT_FLAG};
                        tbl = nxt;
                    end
                end
                if (path_ok)
                    page_store[tbl * ENTRIES_PER_TABLE + level_slot(va, 3)] =
                        {pa[ENTRY_W-1:FLAG_W], pflags | PRESENT_FLAG};
                else
                    r.status = STATUS_NO_MEM;
            end
            CMD_UNMAP, CMD_TRANSLATE:
            begin
                for (lvl = 0; lvl < 3 && path_ok; lvl++)
                begin
                    if (entry_points_to(page_store[tbl * ENTRIES_PER_TABLE + level_slot(va, lvl)],
                                        nxt))
                        tbl = nxt;
                    else
                        path_ok = 1'b0;
                end
                slot = tbl * ENTRIES_PER_TABLE + level_slot(va, 3);
                if (!path_ok)
                    r.status = STATUS_NOT_PRESENT;
                else if (cmd == CMD_UNMAP)
                    page_store[slot] = '0;
                else if (!page_store[slot][0])
                    r.status = STATUS_NOT_PRESENT;
                else
                begin
                    r.phys   = {page_store[slot][ENTRY_W-1:FLAG_W], va[FLAG_W-1:0]};
                    r.mapped = (r.phys != '0);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // idle cycles before a transaction, with stretches of none at all
    function automatic int unsigned idle_draw(int n);
        if ((n / 60) % 3 == 2)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_command(cmd_t cmd, logic [VA_W-1:0] va, logic [ENTRY_W-1:0] pa,
                                 logic [FLAG_W-1:0] pflags);
        page_cmd_t c;
        c.cmd    = cmd;
        c.va     = va;
        c.pa     = pa;
        c.pflags = pflags;
        if (cmd == CMD_MAP)
            known_pages.push_back(va);
        pending_cmds.push_back(c);
        items_total++;
    endtask

    // mostly well-formed traffic over a small address set, some noise
    task automatic queue_random_command();
        int unsigned     pick, lvl;
        logic [VA_W-1:0] va;
        logic [ENTRY_W-1:0] pa;
        cmd_t            cmd;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            cmd = CMD_MAP;
        else if (pick < 60)
            cmd = CMD_UNMAP;
        else if (pick < 95)
            cmd = CMD_TRANSLATE;
        else
            cmd = CMD_NONE;
        if (known_pages.size() != 0 && $urandom_range(0, 99) < 55)
        begin
            va = known_pages[$urandom_range(0, known_pages.size() - 1)];
            va[FLAG_W-1:0] = 12'($urandom);
        end
        else
        begin
            va = 48'({$urandom, $urandom});
            for (lvl = 0; lvl < 4; lvl++)
                if ($urandom_range(0, 99) < 85)
                    va[12 + 9 * (3 - lvl) +: 9] = level_palette[lvl][$urandom_range(0, 3)];
        end
        pa = 52'({$urandom, $urandom});
        if ($urandom_range(0, 19) == 0)
            pa = '0;
        queue_command(cmd, va, pa, 12'($urandom));
    endtask

    task automatic write_entry_flags(logic [FLAG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        entry_flags_model = value;
    endtask

    task automatic wait_until_drained();
        wait (results_count >= items_total);
        @(posedge clk);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        page_cmd_t    it;
        walk_result_t predicted;
        logic         offering;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            offering = s_tvalid;
            // transaction taken: predict its result
            if (s_tvalid && s_tready)
            begin
                predicted = walk_tables(cmd_t'(s_tuser), s_tdata[47:0], s_tdata[99:48],
                                        s_tdata[111:100]);
                expected_results.push_back(predicted);
                sent_count++;
                offering = 1'b0;
            end
            // next command after its gap
            if (!offering && pending_cmds.size() != 0)
            begin
                if (gap_left == 0)
                begin
                    it = pending_cmds.pop_front();
                    s_tdata  <= {it.pflags, it.pa, it.va};
                    s_tuser  <= it.cmd;
                    offering = 1'b1;
                    gap_left <= idle_draw(sent_count);
                end
                else
                    gap_left <= gap_left - 1;
            end
            s_tvalid <= offering;
        end
    end

    // result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        int unsigned  wait_cycles;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d phys %h mapped %0d", $time,
                         m_tuser[1:0], m_tdata[51:0], m_tuser[2]);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser[1:0] != want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             want.status, m_tuser[1:0]);
                    failures++;
                end
                if (m_tdata[51:0] != want.phys)
                begin
                    $display("%0t: phys_result mismatch, expected %h, actual %h", $time,
                             want.phys, m_tdata[51:0]);
                    failures++;
                end
                if (m_tuser[2] != want.mapped)
                begin
                    $display("%0t: mapped mismatch, expected %0d, actual %0d", $time,
                             want.mapped, m_tuser[2]);
                    failures++;
                end
            end
            results_count++;
            // one long hold-off so the engine backs up into its input
            if (results_count == HOLD_AT)
                wait_cycles = HOLD_CYCLES;
            else
                wait_cycles = idle_draw(results_count);
            stall_left <= wait_cycles;
            m_tready   <= (wait_cycles == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin : main_sequence
        int i, lvl, slot;
        for (slot = 0; slot < STORE_ENTRIES; slot++)
            page_store[slot] = '0;
        free_table        = 1;
        entry_flags_model = 12'd3;
        for (lvl = 0; lvl < 4; lvl++)
        begin
            level_palette[lvl][0] = 9'd0;
            level_palette[lvl][1] = 9'd511;
            level_palette[lvl][2] = 9'($urandom);
            level_palette[lvl][3] = 9'($urandom);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // lowest flag setting while the store is swept
        write_entry_flags(12'h000);

        // directed corners
        queue_command(CMD_TRANSLATE, 48'h0, 52'h0, 12'h0);
        queue_command(CMD_UNMAP, 48'h0, 52'h0, 12'h0);
        queue_command(CMD_MAP, 48'h0, 52'h0, 12'h0);
        queue_command(CMD_TRANSLATE, 48'h0, 52'h0, 12'h0);
        queue_command(CMD_TRANSLATE, 48'hFFF, 52'h0, 12'h0);
        queue_command(CMD_MAP, {VA_W{1'b1}}, {ENTRY_W{1'b1}}, 12'hFFF);
        queue_command(CMD_TRANSLATE, {VA_W{1'b1}}, 52'h0, 12'h0);
        queue_command(CMD_MAP, 48'h0, 52'h1_2345_6789_A000, 12'h5A4);
        queue_command(CMD_TRANSLATE, 48'h555, 52'h0, 12'h0);
        queue_command(CMD_UNMAP, {VA_W{1'b1}}, 52'h0, 12'h0);
        queue_command(CMD_TRANSLATE, {VA_W{1'b1}}, 52'h0, 12'h0);
        queue_command(CMD_UNMAP, {VA_W{1'b1}}, 52'h0, 12'h0);
        queue_command(CMD_NONE, {VA_W{1'b1}}, {ENTRY_W{1'b1}}, 12'hFFF);
        queue_command(CMD_NONE, 48'h0, 52'h0, 12'h0);
        // path broken below the root
        queue_command(CMD_UNMAP, 48'h4000_0000, 52'h0, 12'h0);
        queue_command(CMD_TRANSLATE, 48'h4000_0000, 52'h0, 12'h0);
        queue_command(CMD_MAP, 48'h8000_0000_0000, 52'hA_BCDE_F012_3FFF, 12'h800);
        queue_command(CMD_TRANSLATE, 48'h8000_0000_0ABC, 52'h0, 12'h0);
        wait_until_drained();

        // highest flag setting
        write_entry_flags(12'hFFF);
        for (i = 0; i < 240; i++)
            queue_random_command();
        wait_until_drained();

        write_entry_flags(12'($urandom));
        for (i = 0; i < 240; i++)
            queue_random_command();
        wait_until_drained();

        write_entry_flags(12'($urandom));
        for (i = 0; i < 220; i++)
            queue_random_command();
        wait_until_drained();

        // let any stray result show up
        repeat (30) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- four_level_page_table_engine.f -----
rtl/flpte_pkg.sv
rtl/flpte_table_store.sv
rtl/four_level_page_table_engine.sv
dv/testbench.sv
